// File: src/cluster_centroid_accumulator_core_macros.svh
// Assertion macros for the cluster centroid accumulator
`ifndef CLUSTER_CENTROID_ACCUMULATOR_CORE_MACROS_SVH
`define CLUSTER_CENTROID_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication, reset disables the check
`define CCACC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables the check
`define CCACC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ccacc_pkg.sv
// Shared types, widths and defaults for the cluster centroid accumulator
`default_nettype none
package ccacc_pkg;

  localparam int unsigned NumLayersDef = 20;
  localparam int unsigned MaxHitsDef   = 4096;

  localparam int unsigned EtW  = 32;  // total energy, holds 65536 hits of full energy
  localparam int unsigned CsW  = 48;  // energy times coordinate sums
  localparam int unsigned LsW  = 38;  // energy times layer sum
  localparam int unsigned TgW  = 49;  // fraction times energy
  localparam int unsigned DvdW = 56;  // divider dividend
  localparam int unsigned QW   = 24;  // divider quotient bits
  localparam int unsigned QfW  = 17;

  localparam logic [QfW-1:0] QfReset = 17'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_DWAIT,
    ST_TGT,
    ST_WRD,
    ST_WADD,
    ST_QDIV,
    ST_QWAIT,
    ST_DONE
  } ccacc_st_e;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } lyr_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: src/ccacc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module ccacc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccacc_pkg::DvdW-1:0]    dividend_i,
  input  logic [ccacc_pkg::EtW-1:0]     divisor_i,
  output logic [ccacc_pkg::QW-1:0]      quot_o,
  output ccacc_pkg::div_stat_t          stat_o
);
  import ccacc_pkg::*;

  localparam int unsigned CW = $clog2(QW + 1);

  logic [EtW-1:0] rem_q, rem_d, dvs_q;
  logic [QW-1:0]  lo_q;
  logic [CW-1:0]  cnt_q;
  logic           run_q, done_q;
  logic [EtW:0]   trial;
  logic           ge;

  assign trial = {rem_q, lo_q[QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? EtW'(trial - {1'b0, dvs_q}) : trial[EtW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(QW);
    end else if (run_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DvdW-1:QW];
      lo_q  <= dividend_i[QW-1:0];
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[QW-2:0], ge};
    end
  end

  assign quot_o      = lo_q;
  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

// File: src/ccacc_lyr.sv
// Per-layer energy store with valid bits and registered read
`default_nettype none
module ccacc_lyr #(
  parameter int unsigned NUM_LAYERS = ccacc_pkg::NumLayersDef,
  parameter int unsigned AW         = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ccacc_pkg::lyr_req_t       req_i,
  input  logic [AW-1:0]             raddr_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ccacc_pkg::EtW-1:0] wdata_i,
  output logic [ccacc_pkg::EtW-1:0] rdata_o
);
  import ccacc_pkg::*;

  logic [EtW-1:0]        mem [NUM_LAYERS];
  logic [NUM_LAYERS-1:0] vld_q;
  logic [EtW-1:0]        rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.wr) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[waddr_i] <= wdata_i;
    end
    if (req_i.rd) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/cluster_centroid_accumulator_core.sv
// Top level: hit accumulation, serial quotients and layer quantile walk
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  hit in   | in_valid_i / in_ready_o | new_cluster_i, hit_energy_i, hit_x/y/z_i,
//           |                         | hit_layer_i
//  result   | out_valid_o/out_ready_i | centroid_x/y/z_o, mean_layer_o, ...
//  config   | cfg_we_i                | cfg_wdata_i (quantile fraction)
//
// One word at a time: accumulation of the x, y, z and layer products, four quotients
// on the shared bit-serial divider, a target step, a read and an add per layer walked,
// an optional quantile quotient and a load of the result registers; zero cluster
// energy skips the quotients and the walk. Reset clears all sums and sets the
// fraction to one half. A held result stalls the final load and with it the next
// word's accept, since words are taken only in idle.
`default_nettype none
module cluster_centroid_accumulator_core #(
  parameter int unsigned NUM_LAYERS = ccacc_pkg::NumLayersDef,
  parameter int unsigned MAX_HITS   = ccacc_pkg::MaxHitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        new_cluster_i,
  input  logic [15:0] hit_energy_i,
  input  logic signed [15:0] hit_x_i,
  input  logic signed [15:0] hit_y_i,
  input  logic signed [15:0] hit_z_i,
  input  logic [5:0]  hit_layer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [23:0] centroid_x_o,
  output logic signed [23:0] centroid_y_o,
  output logic signed [23:0] centroid_z_o,
  output logic [13:0] mean_layer_o,
  output logic [27:0] cluster_energy_o,
  output logic [14:0] layer_quantile_o,
  output logic        hit_dropped_o,
  output logic        layer_out_of_range_o
);
  import ccacc_pkg::*;
  `include "cluster_centroid_accumulator_core_macros.svh"

  localparam int unsigned AW  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int unsigned KW  = $clog2(NUM_LAYERS + 1);
  localparam int unsigned HCW = $clog2(MAX_HITS + 1);
  localparam logic [14:0] LqMax = 15'((NUM_LAYERS - 1) * 256);

  ccacc_st_e st_q, st_d;

  logic [QfW-1:0]  qf_q;
  logic [1:0]      step_q, di_q;
  logic [15:0]     e_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic [5:0]      lay_q;
  logic            drop_q, oor_q;
  logic [EtW-1:0]  et_q;
  logic signed [CsW-1:0] sx_q, sy_q, sz_q;
  logic [LsW-1:0]  sl_q;
  logic [HCW-1:0]  hc_q;
  logic [23:0]     cx_q, cy_q, cz_q;
  logic [13:0]     ml_q;
  logic [14:0]     lq_q;
  logic [TgW-1:0]  tgt_q;
  logic [EtW-1:0]  cum_q, el_q;
  logic [KW-1:0]   k_q;

  logic            acc, drop_d, oor_d;
  lyr_req_t        lreq;
  logic [AW-1:0]   raddr;
  logic [EtW-1:0]  rdata;
  logic            div_start;
  logic [DvdW-1:0] dvd;
  logic [QW-1:0]   quot;
  div_stat_t       dstat;

  logic signed [16:0] mop;
  logic signed [33:0] prod;
  logic signed [CsW-1:0] ssel;
  logic [CsW-1:0]  smag;
  logic            sneg;
  logic [23:0]     qs;
  logic [TgW-1:0]  cum16, exc;
  logic            walk_go, walk_le;
  logic [14:0]     kq8;

  assign acc    = in_valid_i && in_ready_o;
  assign drop_d = !new_cluster_i && (hc_q >= HCW'(MAX_HITS));
  assign oor_d  = !drop_d && ({1'b0, hit_layer_i} >= 7'(NUM_LAYERS));

  always_comb begin
    case (step_q)
      2'd0:    mop = 17'(x_q);
      2'd1:    mop = 17'(y_q);
      2'd2:    mop = 17'(z_q);
      default: mop = $signed({11'd0, lay_q});
    endcase
  end
  assign prod = $signed({1'b0, e_q}) * mop;

  always_comb begin
    case (di_q)
      2'd0:    ssel = sx_q;
      2'd1:    ssel = sy_q;
      default: ssel = sz_q;
    endcase
  end
  assign sneg  = (di_q != 2'd3) && ssel[CsW-1];
  assign smag  = (di_q == 2'd3) ? CsW'(sl_q) : (sneg ? CsW'(-ssel) : CsW'(ssel));
  assign qs    = sneg ? 24'(-quot) : quot;

  assign cum16   = TgW'({cum_q, 16'd0});
  assign exc     = cum16 - tgt_q;
  assign walk_go = (cum16 < tgt_q) && (k_q < KW'(NUM_LAYERS));
  assign walk_le = cum16 <= tgt_q;
  assign kq8     = 15'(k_q - KW'(1)) << 8;

  assign dvd = (st_q == ST_QDIV) ? DvdW'(exc >> 8) : DvdW'({smag, 8'd0});

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (acc) st_d = ST_ACC;
      ST_ACC:   if (step_q == 2'd3) st_d = ST_DIV;
      ST_DIV:   st_d = (et_q == '0) ? ST_DONE : ST_DWAIT;
      ST_DWAIT: if (dstat.done) st_d = (di_q == 2'd3) ? ST_TGT : ST_DIV;
      ST_TGT:   st_d = ST_WRD;
      ST_WRD: begin
        if (walk_go) st_d = ST_WADD;
        else if (k_q <= KW'(1) || walk_le || el_q == '0) st_d = ST_DONE;
        else st_d = ST_QDIV;
      end
      ST_WADD:  st_d = ST_WRD;
      ST_QDIV:  st_d = ST_QWAIT;
      ST_QWAIT: if (dstat.done) st_d = ST_DONE;
      ST_DONE:  if (!out_valid_o || out_ready_i) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    lreq       = '0;
    raddr      = lay_q[AW-1:0];
    div_start  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        lreq.clr   = in_valid_i && new_cluster_i;
      end
      ST_ACC: begin
        lreq.rd = (step_q == 2'd0) && !drop_q && !oor_q;
        lreq.wr = (step_q == 2'd1) && !drop_q && !oor_q;
      end
      ST_DIV:  div_start = (et_q != '0);
      ST_WRD: begin
        lreq.rd = walk_go;
        raddr   = k_q[AW-1:0];
      end
      ST_QDIV: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      qf_q        <= QfReset;
      out_valid_o <= 1'b0;
      step_q      <= '0;
      di_q        <= '0;
      et_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sz_q        <= '0;
      sl_q        <= '0;
      hc_q        <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) qf_q <= cfg_wdata_i;
      if (st_q == ST_DONE && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (acc) begin
        step_q <= '0;
        di_q   <= '0;
        if (new_cluster_i) begin
          et_q <= '0;
          sx_q <= '0;
          sy_q <= '0;
          sz_q <= '0;
          sl_q <= '0;
          hc_q <= '0;
        end
      end
      if (st_q == ST_ACC) begin
        step_q <= step_q + 2'd1;
        if (!drop_q) begin
          case (step_q)
            2'd0:    sx_q <= sx_q + CsW'(prod);
            2'd1:    sy_q <= sy_q + CsW'(prod);
            2'd2:    sz_q <= sz_q + CsW'(prod);
            default: begin
              sl_q <= sl_q + LsW'(prod);
              et_q <= et_q + EtW'(e_q);
              hc_q <= hc_q + HCW'(1);
            end
          endcase
        end
      end
      if (st_q == ST_DWAIT && dstat.done) di_q <= di_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      e_q    <= hit_energy_i;
      x_q    <= hit_x_i;
      y_q    <= hit_y_i;
      z_q    <= hit_z_i;
      lay_q  <= hit_layer_i;
      drop_q <= drop_d;
      oor_q  <= oor_d;
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
      ml_q   <= '0;
      lq_q   <= '0;
    end
    if (st_q == ST_DWAIT && dstat.done) begin
      case (di_q)
        2'd0:    cx_q <= qs;
        2'd1:    cy_q <= qs;
        2'd2:    cz_q <= qs;
        default: ml_q <= quot[13:0];
      endcase
    end
    if (st_q == ST_TGT) begin
      tgt_q <= TgW'(qf_q * et_q);
      cum_q <= '0;
      el_q  <= '0;
      k_q   <= '0;
    end
    if (st_q == ST_WRD && !walk_go && k_q > KW'(1)) lq_q <= kq8;
    if (st_q == ST_WADD) begin
      cum_q <= cum_q + rdata;
      el_q  <= rdata;
      k_q   <= k_q + KW'(1);
    end
    if (st_q == ST_QWAIT && dstat.done) lq_q <= kq8 - 15'(quot[7:0]);
    if (st_q == ST_DONE && (!out_valid_o || out_ready_i)) begin
      centroid_x_o         <= cx_q;
      centroid_y_o         <= cy_q;
      centroid_z_o         <= cz_q;
      mean_layer_o         <= ml_q;
      cluster_energy_o     <= (et_q > EtW'(28'hFFFFFFF)) ? 28'hFFFFFFF : et_q[27:0];
      layer_quantile_o     <= lq_q;
      hit_dropped_o        <= drop_q;
      layer_out_of_range_o <= oor_q;
    end
  end

  ccacc_lyr #(
    .NUM_LAYERS(NUM_LAYERS),
    .AW        (AW)
  ) u_lyr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq),
    .raddr_i(raddr),
    .waddr_i(lay_q[AW-1:0]),
    .wdata_i(rdata + EtW'(e_q)),
    .rdata_o(rdata)
  );

  ccacc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dvd),
    .divisor_i ((st_q == ST_QDIV) ? el_q : et_q),
    .quot_o    (quot),
    .stat_o    (dstat)
  );

  `CCACC_ASSERT_NEXT(a_busy_after_accept, acc, !in_ready_o, "ready high right after a word")
  `CCACC_ASSERT_NOW(a_drop_excl, out_valid_o, !(hit_dropped_o && layer_out_of_range_o), "both flags")
  `CCACC_ASSERT_NOW(a_ml_range, out_valid_o, mean_layer_o <= 14'd16128, "mean layer above 63")
  `CCACC_ASSERT_NOW(a_lq_range, out_valid_o, layer_quantile_o <= LqMax, "quantile too deep")
  `CCACC_ASSERT_NOW(a_div_idle, div_start, !dstat.busy, "divider started while busy")

endmodule
`default_nettype wire
